FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the cache RTL; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY(label, pre, post, msg)
`define ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

FILE: hw/rtl/lkv_pkg.sv
// Types and constants shared by the LRU key/value cache modules.
package lkv_pkg;

    // Request codes
    localparam logic [1:0] REQ_GET      = 2'd0;
    localparam logic [1:0] REQ_PUT      = 2'd1;
    localparam logic [1:0] REQ_CONTAINS = 2'd2;
    localparam logic [1:0] REQ_CLEAR    = 2'd3;

    // Configuration register
    localparam int         CAP_W      = 5;
    localparam logic [4:0] CAP_RESET  = 5'd16;
    localparam int         APB_DATA_W = 32;
    localparam int         APB_ADDR_W = 3;
    localparam logic       REG_CAPACITY = 1'b0;   // word index of the capacity register

    // Update command broadcast to every cell
    typedef struct packed {
        logic apply;    // commit the request this cycle
        logic shift;    // cells marked by the probe load from their left neighbor
        logic evict;    // the last valid entry drops out of the row
        logic clear;    // invalidate every cell
    } lkv_ctrl_t;

    // Probe token handed from cell to cell
    typedef struct packed {
        logic live;     // token present at this stage
        logic found;    // key matched in an earlier cell
    } lkv_tok_t;

endpackage

FILE: hw/rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache: request control, APB register, cell row.
//
// The entries sit in a row of ENTRIES cells ordered by recency, the most recent in cell 0 and
// the valid entries packed from cell 0 up. A get, put or contains sends a probe token down the
// row one cell per cycle; each cell compares its own key, and the token collects the hit value,
// the key of the last valid entry, and marks the cells that must move. When the token leaves
// the last cell the result is captured; then, on a get hit or a put, every marked cell loads
// its left neighbor at once while cell 0 takes the requested entry, in the same cycle as the
// result enters the output register. A request is taken only while the cache is idle, so the
// next one waits until the previous result has entered the output register. A clear skips the
// probe and goes straight to the update and its result. A result that is not taken holds the
// update back until the output register is free. There is no clearing pass; reset clears the
// valid flags directly.
module lru_key_value_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lkv_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lkv_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lkv_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic [KEY_BITS-1:0]             key,
    input  logic [VALUE_BITS-1:0]           value,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit,
    output logic [VALUE_BITS-1:0]           value_out,
    output logic                            evicted,
    output logic [KEY_BITS-1:0]             evicted_key,
    output logic [CNT_W-1:0]                occupancy
);

    `include "assert_macros.svh"

    localparam int CMP_W = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [1:0]                    op_reg;
    logic [KEY_BITS-1:0]           key_reg;
    logic [VALUE_BITS-1:0]         value_reg;
    logic                          start_reg;
    logic                          found_reg;
    logic [VALUE_BITS-1:0]         fval_reg;
    logic [KEY_BITS-1:0]           lkey_reg;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [lkv_pkg::CAP_W-1:0]     capacity_reg;

    logic                          out_valid_reg;
    logic                          hit_reg;
    logic [VALUE_BITS-1:0]         value_out_reg;
    logic                          evicted_reg;
    logic [KEY_BITS-1:0]           evicted_key_reg;
    logic [CNT_W-1:0]              occupancy_reg;

    logic                          in_xfer;
    logic                          emit;
    logic                          is_get;
    logic                          is_put;
    logic                          is_clear;
    logic [CMP_W-1:0]              cap_ext;
    logic [CMP_W-1:0]              cap_eff;
    logic                          full;
    logic [VALUE_BITS-1:0]         front_value;
    lkv_pkg::lkv_ctrl_t            ctrl;

    logic [ENTRIES-1:0]            cell_valid;
    logic [KEY_BITS-1:0]           cell_key   [ENTRIES];
    logic [VALUE_BITS-1:0]         cell_value [ENTRIES];
    lkv_pkg::lkv_tok_t             tok        [ENTRIES];
    logic [VALUE_BITS-1:0]         tok_value  [ENTRIES];
    logic [KEY_BITS-1:0]           tok_key    [ENTRIES];
    lkv_pkg::lkv_tok_t             tok_last;

    // APB register: always ready, capacity at word 0
    assign pready = 1'b1;
    assign prdata = (paddr[2] == lkv_pkg::REG_CAPACITY)
                  ? {{(lkv_pkg::APB_DATA_W - lkv_pkg::CAP_W){1'b0}}, capacity_reg}
                  : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkv_pkg::CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == lkv_pkg::REG_CAPACITY))
        begin
            capacity_reg <= pwdata[lkv_pkg::CAP_W-1:0];
        end
    end

    // Saturate the capacity to the span of the row; a capacity of 0 counts as 1
    always_comb
    begin
        cap_ext = CMP_W'(capacity_reg);
        priority if (cap_ext == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign full = CMP_W'(count_reg) >= cap_eff;

    // Decode the held request
    assign is_get   = (op_reg == lkv_pkg::REQ_GET);
    assign is_put   = (op_reg == lkv_pkg::REQ_PUT);
    assign is_clear = (op_reg == lkv_pkg::REQ_CLEAR);

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign emit     = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign tok_last = tok[ENTRIES-1];

    // Update command for the row
    always_comb
    begin
        ctrl.apply = emit;
        ctrl.clear = is_clear;
        ctrl.shift = (is_get && found_reg) || is_put;
        ctrl.evict = is_put && !found_reg && full;
    end

    assign front_value = is_put ? value_reg : fval_reg;

    // Sequence a request: probe (skipped for a clear), then update and emit
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (req_type == lkv_pkg::REQ_CLEAR) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tok_last.live)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Next occupancy
    always_comb
    begin
        count_next = count_reg;
        priority if (is_clear)
        begin
            count_next = '0;
        end
        else if (is_put && !found_reg && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            start_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= in_xfer && (req_type != lkv_pkg::REQ_CLEAR);
            if (emit)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Hold the request and capture the probe result
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg    <= req_type;
            key_reg   <= key;
            value_reg <= value;
            found_reg <= 1'b0;
        end
        else if ((state_reg == S_SCAN) && tok_last.live)
        begin
            found_reg <= tok_last.found;
            fval_reg  <= tok_value[ENTRIES-1];
            lkey_reg  <= tok_key[ENTRIES-1];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            hit_reg         <= !is_clear && found_reg;
            value_out_reg   <= (is_get && found_reg) ? fval_reg : '0;
            evicted_reg     <= ctrl.evict;
            evicted_key_reg <= ctrl.evict ? lkey_reg : '0;
            occupancy_reg   <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign value_out   = value_out_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;
    assign occupancy   = occupancy_reg;

    // Row of cells, most recent entry first
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic                  left_valid;
        logic [KEY_BITS-1:0]   left_key;
        logic [VALUE_BITS-1:0] left_value;
        lkv_pkg::lkv_tok_t     tok_in;
        logic [VALUE_BITS-1:0] tok_in_value;
        logic [KEY_BITS-1:0]   tok_in_key;

        if (i == 0)
        begin : g_head
            assign left_valid   = 1'b1;
            assign left_key     = key_reg;
            assign left_value   = front_value;
            assign tok_in.live  = start_reg;
            assign tok_in.found = 1'b0;
            assign tok_in_value = '0;
            assign tok_in_key   = '0;
        end
        else
        begin : g_body
            assign left_valid   = cell_valid[i-1];
            assign left_key     = cell_key[i-1];
            assign left_value   = cell_value[i-1];
            assign tok_in       = tok[i-1];
            assign tok_in_value = tok_value[i-1];
            assign tok_in_key   = tok_key[i-1];
        end

        lkv_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .req_key      (key_reg),
            .left_valid   (left_valid),
            .left_key     (left_key),
            .left_value   (left_value),
            .tok_in       (tok_in),
            .tok_in_value (tok_in_value),
            .tok_in_key   (tok_in_key),
            .cell_valid   (cell_valid[i]),
            .cell_key     (cell_key[i]),
            .cell_value   (cell_value[i]),
            .tok_out      (tok[i]),
            .tok_out_value(tok_value[i]),
            .tok_out_key  (tok_key[i])
        );
    end

    // The number of valid cells matches the occupancy
    `ASSERT_ALWAYS(a_count_matches_valid, $countones(cell_valid) == count_reg, "occupancy differs from valid cells")
    // The probe leaves the row only while a request is being looked up
    `ASSERT_IMPLY(a_probe_in_scan, tok_last.live, state_reg == S_SCAN, "probe left the row outside a lookup")
    // An update never overwrites a result that is still waiting
    `ASSERT_IMPLY(a_emit_free, ctrl.apply, !out_valid_reg || out_ready, "result overwritten before transfer")
    // An eviction keeps the occupancy unchanged
    `ASSERT_NEXT(a_evict_keeps_count, ctrl.apply && ctrl.evict, count_reg == $past(count_reg), "eviction changed the occupancy")

endmodule

FILE: hw/rtl/lkv_cell.sv
// One entry of the recency-ordered row: holds a key/value pair and passes the probe on.
module lkv_cell #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lkv_pkg::lkv_ctrl_t    ctrl,
    input  logic [KEY_BITS-1:0]   req_key,
    // entry of the next more recent position
    input  logic                  left_valid,
    input  logic [KEY_BITS-1:0]   left_key,
    input  logic [VALUE_BITS-1:0] left_value,
    // probe from the left neighbor
    input  lkv_pkg::lkv_tok_t     tok_in,
    input  logic [VALUE_BITS-1:0] tok_in_value,
    input  logic [KEY_BITS-1:0]   tok_in_key,
    // own entry
    output logic                  cell_valid,
    output logic [KEY_BITS-1:0]   cell_key,
    output logic [VALUE_BITS-1:0] cell_value,
    // probe to the right neighbor
    output lkv_pkg::lkv_tok_t     tok_out,
    output logic [VALUE_BITS-1:0] tok_out_value,
    output logic [KEY_BITS-1:0]   tok_out_key
);

    logic                  valid_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  shift_reg;
    lkv_pkg::lkv_tok_t     tok_reg;
    logic [VALUE_BITS-1:0] tok_value_reg;
    logic [KEY_BITS-1:0]   tok_key_reg;
    logic                  match;
    logic                  load;

    assign match = valid_reg && (key_reg == req_key);
    assign load  = ctrl.apply && ctrl.shift && shift_reg;

    // Advance the probe and mark whether this cell moves on update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            shift_reg <= 1'b0;
        end
        else
        begin
            tok_reg.live  <= tok_in.live;
            tok_reg.found <= tok_in.live && (tok_in.found || match);
            if (tok_in.live)
            begin
                shift_reg <= !tok_in.found;
            end
        end
    end

    // Carry the hit value and the key of the last valid entry
    always_ff @(posedge clk)
    begin
        if (tok_in.live)
        begin
            tok_value_reg <= match ? value_reg : tok_in_value;
            tok_key_reg   <= valid_reg ? key_reg : tok_in_key;
        end
    end

    // Update the valid flag; drop the entry that falls past the old last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.apply && ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= left_valid && !(ctrl.evict && !valid_reg);
        end
    end

    // Take the neighbor's entry on a shift
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg   <= left_key;
            value_reg <= left_value;
        end
    end

    assign cell_valid    = valid_reg;
    assign cell_key      = key_reg;
    assign cell_value    = value_reg;
    assign tok_out       = tok_reg;
    assign tok_out_value = tok_value_reg;
    assign tok_out_key   = tok_key_reg;

endmodule

FILE: verif/lkv_checker.sv
// Reply checker for the LRU key/value cache: tracks the cache contents and compares every reply.
module lkv_checker #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [lkv_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lkv_pkg::APB_DATA_W-1:0]    pwdata,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [1:0]                        req_type,
    input  logic [KEY_BITS-1:0]               key,
    input  logic [VALUE_BITS-1:0]             value,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              hit,
    input  logic [VALUE_BITS-1:0]             value_out,
    input  logic                              evicted,
    input  logic [KEY_BITS-1:0]               evicted_key,
    input  logic [CNT_W-1:0]                  occupancy,
    output int                                fail_count,
    output int                                open_count,
    output int                                reply_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lkv_pkg::APB_ADDR_W-1:0] CAP_ADDR = {lkv_pkg::REG_CAPACITY, 2'b00};

    typedef struct {
        logic                  hit;
        logic [VALUE_BITS-1:0] value_out;
        logic                  evicted;
        logic [KEY_BITS-1:0]   evicted_key;
        logic [CNT_W-1:0]      occupancy;
    } reply_t;

    // Shadow copy of the cache and its capacity register
    logic                       line_valid [ENTRIES];
    logic [KEY_BITS-1:0]        line_key   [ENTRIES];
    logic [VALUE_BITS-1:0]      line_data  [ENTRIES];
    int unsigned                line_age   [ENTRIES];
    int unsigned                line_count;
    logic [lkv_pkg::CAP_W-1:0]  cap_reg;

    reply_t awaited_replies [$];
    int     errors;
    int     seen;

    // Make one entry the most recent, aging everything that was newer
    function automatic void make_newest(input int slot);
        int unsigned old_age;
        old_age = line_age[slot];
        for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i] && line_age[i] < old_age)
                line_age[i]++;
        line_age[slot] = 0;
    endfunction

    // Apply one request to the shadow cache and return its reply
    function automatic reply_t serve_request(input logic [1:0] kind,
                                             input logic [KEY_BITS-1:0] k,
                                             input logic [VALUE_BITS-1:0] v);
        reply_t r;
        int     slot;
        int     oldest;
        int     eff_cap;
        r.hit         = 1'b0;
        r.value_out   = '0;
        r.evicted     = 1'b0;
        r.evicted_key = '0;
        eff_cap = (cap_reg == 0) ? 1 : ((int'(cap_reg) > ENTRIES) ? ENTRIES : int'(cap_reg));
        if (kind == lkv_pkg::REQ_CLEAR)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                line_valid[i] = 1'b0;
                line_age[i]   = 0;
            end
            line_count = 0;
        end
        else
        begin
            slot = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && line_valid[i] && line_key[i] == k)
                    slot = i;
            r.hit = (slot >= 0);
            if (kind == lkv_pkg::REQ_GET && slot >= 0)
            begin
                r.value_out = line_data[slot];
                make_newest(slot);
            end
            else if (kind == lkv_pkg::REQ_PUT && slot >= 0)
            begin
                line_data[slot] = v;
                make_newest(slot);
            end
            else if (kind == lkv_pkg::REQ_PUT)
            begin
                // Full: drop the least recent entry first
                if (line_count >= eff_cap)
                begin
                    oldest = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (line_valid[i] && (oldest < 0 || line_age[i] > line_age[oldest]))
                            oldest = i;
                    if (oldest >= 0)
                    begin
                        r.evicted          = 1'b1;
                        r.evicted_key      = line_key[oldest];
                        line_valid[oldest] = 1'b0;
                        line_age[oldest]   = 0;
                        line_count--;
                    end
                end
                // Insert into the lowest free slot as most recent
                slot = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !line_valid[i])
                        slot = i;
                if (slot >= 0)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (line_valid[i])
                            line_age[i]++;
                    line_valid[slot] = 1'b1;
                    line_key[slot]   = k;
                    line_data[slot]  = v;
                    line_age[slot]   = 0;
                    line_count++;
                end
            end
        end
        r.occupancy = CNT_W'(line_count);
        return r;
    endfunction

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                line_valid[i] = 1'b0;
                line_key[i]   = '0;
                line_data[i]  = '0;
                line_age[i]   = 0;
            end
            line_count = 0;
            cap_reg    = lkv_pkg::CAP_RESET;
            awaited_replies.delete();
            errors      = 0;
            seen        = 0;
            fail_count  <= 0;
            open_count  <= 0;
            reply_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
                cap_reg = pwdata[lkv_pkg::CAP_W-1:0];

            // Compare the reply transfer with the oldest prediction
            if (out_valid && out_ready)
            begin
                seen++;
                if (awaited_replies.size() == 0)
                begin
                    $error("reply with no request waiting: occupancy %0d", occupancy);
                    errors++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", want.hit, hit);
                        errors++;
                    end
                    if (value_out !== want.value_out)
                    begin
                        $error("value_out: expected %h, actual %h", want.value_out, value_out);
                        errors++;
                    end
                    if (evicted !== want.evicted)
                    begin
                        $error("evicted: expected %0d, actual %0d", want.evicted, evicted);
                        errors++;
                    end
                    if (evicted_key !== want.evicted_key)
                    begin
                        $error("evicted_key: expected %h, actual %h",
                               want.evicted_key, evicted_key);
                        errors++;
                    end
                    if (occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, actual %0d", want.occupancy, occupancy);
                        errors++;
                    end
                end
            end

            // Predict the reply of each request transfer
            if (in_valid && in_ready)
                awaited_replies.push_back(serve_request(req_type, key, value));

            fail_count  <= errors;
            open_count  <= awaited_replies.size();
            reply_count <= seen;
        end
    end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the LRU key/value cache: clock, reset, request traffic and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int POOL_SIZE  = 40;
    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 85;
    localparam logic [lkv_pkg::APB_ADDR_W-1:0] CAP_ADDR = {lkv_pkg::REG_CAPACITY, 2'b00};

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [lkv_pkg::APB_ADDR_W-1:0]    paddr = '0;
    logic [lkv_pkg::APB_DATA_W-1:0]    pwdata = '0;
    logic [lkv_pkg::APB_DATA_W-1:0]    prdata;
    logic                              pready;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [1:0]                        req_type = lkv_pkg::REQ_GET;
    logic [KEY_BITS-1:0]               key = '0;
    logic [VALUE_BITS-1:0]             value = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic                              hit;
    logic [VALUE_BITS-1:0]             value_out;
    logic                              evicted;
    logic [KEY_BITS-1:0]               evicted_key;
    logic [CNT_W-1:0]                  occupancy;

    int fail_count;
    int open_count;
    int reply_count;
    int sent_count = 0;
    int settings_used = 0;

    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

    lru_key_value_cache #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .value_out   (value_out),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .occupancy   (occupancy)
    );

    lkv_checker #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) reply_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .value_out   (value_out),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .occupancy   (occupancy),
        .fail_count  (fail_count),
        .open_count  (open_count),
        .reply_count (reply_count)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offer one request and hold it until the transfer
    task automatic send_request(input logic [1:0] kind, input logic [KEY_BITS-1:0] k,
                                input logic [VALUE_BITS-1:0] v);
        in_valid <= 1'b1;
        req_type <= kind;
        key      <= k;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    // Write the capacity register: setup cycle, then access cycle
    task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= lkv_pkg::APB_DATA_W'(cap);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // Stop offering and wait until every reply is back, then let the row settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (open_count != 0)
            @(posedge clk);
        repeat (ENTRIES + 4) @(posedge clk);
    endtask

    // Random request, keys mostly from a pool a bit larger than the capacity
    task automatic send_random(input int span);
        int                    pick;
        logic [1:0]            kind;
        logic [KEY_BITS-1:0]   k;
        logic [VALUE_BITS-1:0] v;
        pick = $urandom_range(99);
        if (pick < 2)
            kind = lkv_pkg::REQ_CLEAR;
        else if (pick < 42)
            kind = lkv_pkg::REQ_PUT;
        else if (pick < 74)
            kind = lkv_pkg::REQ_GET;
        else
            kind = lkv_pkg::REQ_CONTAINS;
        if ($urandom_range(9) == 0)
            k = $urandom;
        else
            k = key_pool[$urandom_range(span - 1)];
        case ($urandom_range(15))
            0:       v = '0;
            1:       v = '1;
            default: v = $urandom;
        endcase
        send_request(kind, k, v);
    endtask

    // Bursts of random requests with random gaps between them
    task automatic run_phase(input int count, input int span);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && left > 0; j++)
            begin
                send_random(span);
                left--;
            end
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Reply side: stall patterns, with one long hold-off to back up the request side
    initial
    begin : result_sink
        int  mode;
        int  span;
        int  tick;
        bit  held;
        tick = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && reply_count >= 120)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                held = 1'b1;
            end
            mode = $urandom_range(2);
            span = $urandom_range(20, 150);
            repeat (span)
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(9) < 6);
                    default: out_ready <= ((tick % 5) < 2);
                endcase
                tick++;
                @(posedge clk);
            end
        end
    end

    // Request traffic and verdict
    initial
    begin : stimulus
        logic [lkv_pkg::CAP_W-1:0] caps [PHASES];
        bit                        clear_first [PHASES];
        int                        eff_cap;
        int                        span;
        caps        = '{5'd4, 5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd9, 5'd12};
        clear_first = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        caps[PHASES-1] = lkv_pkg::CAP_W'($urandom_range(3, 15));
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: hits, misses, promotion, eviction order, overwrite, clear
        write_capacity(5'd3);
        send_request(lkv_pkg::REQ_PUT,      32'h0000_0000, 32'hFFFF_FFFF);
        send_request(lkv_pkg::REQ_PUT,      32'hFFFF_FFFF, 32'h0000_0000);
        send_request(lkv_pkg::REQ_GET,      32'h0000_0000, 32'h1234_5678);
        send_request(lkv_pkg::REQ_CONTAINS, 32'hFFFF_FFFF, 32'h0);
        send_request(lkv_pkg::REQ_GET,      32'h1234_5678, 32'h0);
        send_request(lkv_pkg::REQ_CONTAINS, 32'h1234_5678, 32'h0);
        send_request(lkv_pkg::REQ_PUT,      32'h0000_0005, 32'hA5A5_A5A5);
        send_request(lkv_pkg::REQ_PUT,      32'h0000_0006, 32'h5A5A_5A5A);
        send_request(lkv_pkg::REQ_GET,      32'hFFFF_FFFF, 32'h0);
        send_request(lkv_pkg::REQ_PUT,      32'h0000_0000, 32'h0000_0001);
        send_request(lkv_pkg::REQ_GET,      32'h0000_0000, 32'h0);
        send_request(lkv_pkg::REQ_GET,      32'h0000_0005, 32'h0);
        send_request(lkv_pkg::REQ_PUT,      32'h0000_0007, 32'hFFFF_0000);
        send_request(lkv_pkg::REQ_CONTAINS, 32'h0000_0005, 32'h0);
        send_request(lkv_pkg::REQ_CONTAINS, 32'h0000_0006, 32'h0);
        send_request(lkv_pkg::REQ_CLEAR,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(lkv_pkg::REQ_GET,      32'h0000_0000, 32'h0);
        send_request(lkv_pkg::REQ_PUT,      32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(lkv_pkg::REQ_GET,      32'hFFFF_FFFF, 32'h0);
        send_request(lkv_pkg::REQ_CLEAR,    32'h0,         32'h0);
        wait_drained();

        // Random phases, some changing capacity with the store still full
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (clear_first[ph])
            begin
                send_request(lkv_pkg::REQ_CLEAR, $urandom, $urandom);
                wait_drained();
            end
            write_capacity(caps[ph]);
            eff_cap = (caps[ph] == 0) ? 1 : ((int'(caps[ph]) > ENTRIES) ? ENTRIES : caps[ph]);
            span = eff_cap + $urandom_range(1, 8);
            if (span > POOL_SIZE)
                span = POOL_SIZE;
            run_phase(PHASE_REQS, span);
            wait_drained();
        end

        repeat (ENTRIES + 8) @(posedge clk);
        $display("Ran %0d requests (get, put, contains, clear) over %0d capacity settings.",
                 sent_count, settings_used);
        $display("Checked %0d replies, %0d mismatches.", reply_count, fail_count);
        if (fail_count == 0 && open_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Run limit
    initial
    begin : watchdog
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: lru_key_value_cache.f
+incdir+hw/rtl
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_cell.sv
hw/rtl/lru_key_value_cache.sv
verif/lkv_checker.sv
verif/tb_top.sv
